/* rtl/rss_pkg.sv */
// ----------------------------------------------------------------------------
// rss_pkg
// Shared constants, field layout and controller/datapath interface types for
// the rotated sorted search block.
// ----------------------------------------------------------------------------
package rss_pkg;

  // Entry store depth and derived widths.
  localparam int DEPTH  = 1024;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // Signed search bounds must hold -1 up to DEPTH.
  localparam int IDX_W  = ADDR_W + 2;

  localparam int DATA_W = 32;
  localparam int LEN_W  = 11;
  localparam int EIDX_W = 10;

  // Stream payload layout.
  localparam int IN_FIELDS_W  = EIDX_W + DATA_W + DATA_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W  = 8;

  localparam int EIDX_LSB  = 0;
  localparam int EVAL_LSB  = EIDX_LSB + EIDX_W;
  localparam int KEY_LSB   = EVAL_LSB + DATA_W;

  // Operation codes carried on in_tuser.
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // Configuration port.
  localparam int          CFG_ADDR_W       = 3;
  localparam int          CFG_DATA_W       = 32;
  localparam logic        REG_ARRAY_LENGTH = 1'b0;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr;       // store the incoming entry
    logic load;     // start a search: set bounds and key
    logic issue;    // read the middle and low entries
    logic read_hi;  // keep the low entry, read the high entry
    logic probe;    // narrow the range after a miss
  } rss_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;    // search range has run out
    logic hit;      // middle entry equals the key
  } rss_sts_t;

endpackage

/* rtl/rss_dp.sv */
// ----------------------------------------------------------------------------
// rss_dp
// Datapath: entry memory with two registered read ports, search bounds and
// the probe compare that narrows the range.
// ----------------------------------------------------------------------------
module rss_dp import rss_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  rss_cmd_t                 cmd,
  input  logic [EIDX_W-1:0]        in_entry_index,
  input  logic signed [DATA_W-1:0] in_entry_value,
  input  logic signed [DATA_W-1:0] in_search_key,
  input  logic [LEN_W-1:0]         array_length,
  output rss_sts_t                 sts
);

  logic signed [DATA_W-1:0] mem [DEPTH];

  logic signed [IDX_W-1:0]  lo_r, lo_nxt;
  logic signed [IDX_W-1:0]  hi_r, hi_nxt;
  logic signed [DATA_W-1:0] key_r;
  logic signed [DATA_W-1:0] vl_r;
  logic signed [DATA_W-1:0] rd0_r;
  logic signed [DATA_W-1:0] rd1_r;

  logic signed [IDX_W-1:0]  span;
  logic signed [IDX_W-1:0]  mid;
  logic [ADDR_W-1:0]        rd1_addr;
  logic [31:0]              wr_idx;
  logic [31:0]              len_ext;
  logic [31:0]              len_clip;
  logic                     wr_ok;

  assign span = hi_r - lo_r;
  assign mid  = lo_r + (span >>> 1);

  assign wr_idx  = 32'(in_entry_index);
  assign wr_ok   = wr_idx < 32'(DEPTH);
  assign len_ext = 32'(array_length);
  assign len_clip = (len_ext > 32'(DEPTH)) ? 32'(DEPTH) : len_ext;

  assign rd1_addr = cmd.issue ? lo_r[ADDR_W-1:0] : hi_r[ADDR_W-1:0];

  // Entry memory: one write port, two read ports with registered data.
  always_ff @(posedge clk) begin
    if (cmd.wr && wr_ok) begin
      mem[wr_idx[ADDR_W-1:0]] <= in_entry_value;
    end
    if (cmd.issue) begin
      rd0_r <= mem[mid[ADDR_W-1:0]];
    end
    if (cmd.issue || cmd.read_hi) begin
      rd1_r <= mem[rd1_addr];
    end
  end

  // During the compare cycle rd0_r holds the middle entry, vl_r the low
  // entry and rd1_r the high entry.
  always_comb begin
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    if (vl_r <= rd0_r) begin
      if (key_r >= vl_r && key_r < rd0_r) begin
        hi_nxt = mid - IDX_W'(1);
      end else begin
        lo_nxt = mid + IDX_W'(1);
      end
    end else begin
      if (key_r > rd0_r && key_r <= rd1_r) begin
        lo_nxt = mid + IDX_W'(1);
      end else begin
        hi_nxt = mid - IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lo_r  <= '0;
      hi_r  <= IDX_W'(len_clip) - IDX_W'(1);
      key_r <= in_search_key;
    end else if (cmd.probe) begin
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
    end
    if (cmd.read_hi) begin
      vl_r <= rd1_r;
    end
  end

  assign sts.empty = lo_r > hi_r;
  assign sts.hit   = key_r == rd0_r;

  // Every probe after a miss must shrink the range, so a search ends.
  a_range_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.probe |=> span < $past(span))
    else $error("search range did not shrink after a probe");

  // Reads are only issued over a non-empty range.
  a_issue_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> (lo_r <= hi_r && lo_r >= 0))
    else $error("read issued outside the search range");

endmodule

/* rtl/rss_ctrl.sv */
// ----------------------------------------------------------------------------
// rss_ctrl
// Controller: accepts beats, sequences the probes of a search and holds the
// result register of the output channel.
// ----------------------------------------------------------------------------
module rss_ctrl import rss_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  input  logic     in_op,
  output logic     in_tready,
  input  logic     out_tready,
  output logic     out_tvalid,
  output logic     out_found,
  input  rss_sts_t sts,
  output rss_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ISSUE,
    S_HI,
    S_CMP,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_found_r, out_found_nxt;
  logic   found_r, found_nxt;
  logic   accept;

  assign in_tready  = state_r == S_IDLE;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_found  = out_found_r;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    found_nxt     = found_r;
    out_found_nxt = out_found_r;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_op == OP_SEARCH) begin
            cmd.load  = 1'b1;
            state_nxt = S_ISSUE;
          end else begin
            cmd.wr = 1'b1;
          end
        end
      end
      S_ISSUE: begin
        if (sts.empty) begin
          found_nxt = 1'b0;
          state_nxt = S_DONE;
        end else begin
          cmd.issue = 1'b1;
          state_nxt = S_HI;
        end
      end
      S_HI: begin
        cmd.read_hi = 1'b1;
        state_nxt   = S_CMP;
      end
      S_CMP: begin
        if (sts.hit) begin
          found_nxt = 1'b1;
          state_nxt = S_DONE;
        end else begin
          cmd.probe = 1'b1;
          state_nxt = S_ISSUE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = found_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    found_r     <= found_nxt;
    out_found_r <= out_found_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // The compare cycle always follows the high-entry read.
  a_cmp_after_hi: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CMP |-> $past(state_r) == S_HI)
    else $error("compare without a preceding high-entry read");

  // A new result only appears when a search has finished.
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result raised outside the done state");

  // A finished search waits while the output register is still occupied.
  a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_valid_r && !out_tready) |=> state_r == S_DONE)
    else $error("result register overwritten while stalled");

endmodule

/* rtl/rotated_sorted_search_top.sv */
// ----------------------------------------------------------------------------
// rotated_sorted_search_top
// Binary search over a rotated ascending array of signed 32-bit entries.
// ----------------------------------------------------------------------------
// The input stream carries two kinds of beat, told apart by in_tuser. A
// write beat stores entry_value at entry_index in the entry memory and gives
// no result. A search beat looks for search_key among entries 0 to
// array_length-1 and gives exactly one result beat whose found bit says
// whether an equal entry was reached. array_length is set through the APB
// port at byte address 0 and is clipped to the memory depth.
//
// A write beat is stored when it is accepted, and the input stays ready for
// the next beat. A search beat steps through an issue, a high-entry read and
// a compare on each probe, with at most eleven probes for 1024 entries; a
// search that runs out of range visits the issue state once more to see the
// empty range. The input is ready again from the edge that loads the result.
// The probe steps are set by the entry memory, which has two read ports,
// while each probe needs the low, middle and high entries: a read of the
// middle and low entries, a read of the high entry, and a compare.
//
// The result sits in an output register, so the next beat is accepted while
// a result waits. If the receiver stalls and a second search finishes, that
// search holds until the register is free. Reset clears the controller
// state, the result valid flag and array_length; the entry memory is not
// cleared and must be written before it is searched.
// ----------------------------------------------------------------------------
module rotated_sorted_search_top import rss_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  // Input stream.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // in_tdata, from bit 0: entry_index[9:0], entry_value[41:10],
  // search_key[73:42], zero padding[79:74].
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // in_tuser, bit 0: op (0 write, 1 search).
  input  logic                   in_tuser,
  // Result stream.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // out_tdata, from bit 0: found[0], zero padding[7:1].
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // Configuration port.
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [CFG_DATA_W-1:0]  cfg_prdata,
  output logic                   cfg_pready
);

  logic [LEN_W-1:0] array_length_r;
  logic             cfg_wr;
  logic             out_found;
  rss_cmd_t         cmd;
  rss_sts_t         sts;

  // The register index is the word address; the byte offset bits are ignored.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      array_length_r <= '0;
    end else if (cfg_wr && cfg_paddr[2] == REG_ARRAY_LENGTH) begin
      array_length_r <= cfg_pwdata[LEN_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_ARRAY_LENGTH) ?
                      CFG_DATA_W'(array_length_r) : '0;

  rss_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_op      (in_tuser),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_found  (out_found),
    .sts        (sts),
    .cmd        (cmd)
  );

  rss_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_entry_index (in_tdata[EIDX_LSB +: EIDX_W]),
    .in_entry_value (in_tdata[EVAL_LSB +: DATA_W]),
    .in_search_key  (in_tdata[KEY_LSB +: DATA_W]),
    .array_length   (array_length_r),
    .sts            (sts)
  );

  assign out_tdata = OUT_TDATA_W'(out_found);

endmodule

/* bench/tb_rotated_sorted_search_top.sv */
// ----------------------------------------------------------------------------
// tb_rotated_sorted_search_top
// Self-checking bench for the rotated sorted search block.
// ----------------------------------------------------------------------------
// Write beats load the entry memory with rotated ascending runs, flat runs
// full of duplicates and unsorted noise. Search beats then look for keys
// that are mostly present, sometimes one off, and sometimes random or
// extreme. A behavioural copy of the search predicts every found bit. The
// array length is changed over APB only while the block is quiet. Both
// stream sides idle at random, and the result side holds off once for a
// long stretch so that the block backs up onto its input.
// ----------------------------------------------------------------------------
module tb_rotated_sorted_search_top;
  import rss_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int IDLE_PCT     = 24;
  localparam int SETTLE_CYCLES = 40;     // a full eleven-probe search, with margin
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AFTER   = 150;     // searches accepted before the long hold-off
  localparam int REG_STRIDE   = 4;
  localparam int REG_SPARE    = 1;       // decodes to no register
  localparam int RUN_LIMIT    = 5_000_000;

  localparam logic signed [DATA_W-1:0] INT_LO = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] INT_HI = 32'sh7FFF_FFFF;

  typedef enum int {FILL_KEEP, FILL_ROTATED, FILL_FLAT, FILL_NOISE} fill_kind_t;

  typedef struct {
    logic                     op;
    logic [EIDX_W-1:0]        idx;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] key;
  } beat_t;

  // DUT ports; every input starts at a known value.
  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata    = '0;
  logic                   in_tuser    = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_psel    = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0]  cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0]  cfg_prdata;
  logic                   cfg_pready;

  // Predictor state: the entry memory and the length register as the
  // block should hold them.
  logic signed [DATA_W-1:0] shadow_entry [DEPTH];
  logic [LEN_W-1:0]         search_len = '0;

  // Stimulus-side view of what has been queued, used to pick keys and to
  // make sure no search ever reads an entry that was never written.
  logic signed [DATA_W-1:0] planned [DEPTH];
  bit                       loaded  [DEPTH];

  beat_t pending[$];          // beats waiting for the driver
  beat_t offered;             // beat currently on the input bus
  logic  expected_found[$];   // found bits still owed by the block

  bit  no_gaps     = 1'b0;
  int  items_total = 0;
  int  writes_taken = 0;
  int  searches_taken = 0;
  int  hits_seen   = 0;
  int  mismatches  = 0;
  int  lengths_set = 0;
  int  hold_left   = 0;
  bit  hold_used   = 1'b0;

  rotated_sorted_search_top u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),    // entry_index, entry_value, search_key, zero pad
    .in_tuser    (in_tuser),    // op
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),   // found, zero pad
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #CLK_HALF clk = ~clk;

  // Hard stop in case the block hangs or loses a result.
  initial begin
    #RUN_LIMIT;
    $display("rotated_sorted_search_top test failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Binary search over a rotated run. Whichever half is in order decides
  // where the key can lie; a length above the memory depth is clipped.
  function automatic logic rotated_lookup(input logic signed [DATA_W-1:0] key);
    int n, lo, hi, mid;
    logic signed [DATA_W-1:0] vl, vm, vh;
    n  = (search_len > DEPTH) ? DEPTH : int'(search_len);
    lo = 0;
    hi = n - 1;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      vm  = shadow_entry[mid];
      vl  = shadow_entry[lo];
      vh  = shadow_entry[hi];
      if (key == vm) return 1'b1;
      if (vl <= vm) begin
        if (key >= vl && key < vm) hi = mid - 1;
        else lo = mid + 1;
      end else begin
        if (key > vm && key <= vh) lo = mid + 1;
        else hi = mid - 1;
      end
    end
    return 1'b0;
  endfunction

  function automatic logic [IN_TDATA_W-1:0] pack_beat(input beat_t b);
    logic [IN_TDATA_W-1:0] d;
    d = '0;
    d[EIDX_LSB +: EIDX_W] = b.idx;
    d[EVAL_LSB +: DATA_W] = b.value;
    d[KEY_LSB  +: DATA_W] = b.key;
    return d;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    mismatches++;
  endtask

  // --------------------------------------------------------------------------
  // Input driver. A beat that was offered stays on the bus until it is
  // taken; a new beat (or a gap) is chosen only once the bus is free.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive_in
    beat_t nb;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        // The beat is taken at this edge: update the predictor in order.
        if (offered.op == OP_WRITE) begin
          shadow_entry[offered.idx] = offered.value;
          writes_taken <= writes_taken + 1;
        end else begin
          expected_found.push_back(rotated_lookup(offered.key));
          searches_taken <= searches_taken + 1;
        end
      end
      if (!in_tvalid || in_tready) begin
        if (pending.size() != 0 && (no_gaps || $urandom_range(99) >= IDLE_PCT)) begin
          nb        = pending.pop_front();
          offered   = nb;
          in_tvalid <= 1'b1;
          in_tdata  <= pack_beat(nb);
          in_tuser  <= nb.op;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // The long hold-off is timed here, apart from the monitor, and starts
  // once enough searches have gone in to keep the block busy.
  always @(posedge clk) begin : hold_timer
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_used && searches_taken >= HOLD_AFTER) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: each result beat is matched against the oldest
  // outstanding found bit.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : watch_out
    logic want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_found.size() == 0) begin
          report_mismatch($sformatf("result beat found=%0b with no search outstanding",
                                    out_tdata[0]));
        end else begin
          want = expected_found.pop_front();
          if (out_tdata[0] !== want)
            report_mismatch($sformatf("found=%0b, expected %0b", out_tdata[0], want));
        end
        if (out_tdata[0] === 1'b1) hits_seen++;
      end
      out_tready <= (hold_left != 0) ? 1'b0 : (no_gaps || $urandom_range(99) >= IDLE_PCT);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  task automatic push_write(input int idx, input logic signed [DATA_W-1:0] val);
    beat_t b;
    b.op    = OP_WRITE;
    b.idx   = EIDX_W'(idx);
    b.value = val;
    b.key   = $urandom;        // ignored by a write
    pending.push_back(b);
    planned[idx] = val;
    loaded[idx]  = 1'b1;
    items_total++;
  endtask

  task automatic push_search(input logic signed [DATA_W-1:0] key);
    beat_t b;
    b.op    = OP_SEARCH;
    b.idx   = EIDX_W'($urandom);   // ignored by a search
    b.value = $urandom;
    b.key   = key;
    pending.push_back(b);
    items_total++;
  endtask

  // Wait until every queued beat is in and every result is out, then give
  // a trailing write beat time to finish before anything else happens.
  task automatic wait_quiet();
    do @(negedge clk);
    while (pending.size() != 0 || in_tvalid || expected_found.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // APB write: setup cycle, then the access cycle in which it is taken.
  task automatic cfg_write(input int index, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_W'(index * REG_STRIDE);
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (index == int'(REG_ARRAY_LENGTH)) search_len = value[LEN_W-1:0];
    @(negedge clk);
  endtask

  task automatic set_length(input logic [CFG_DATA_W-1:0] len);
    wait_quiet();
    cfg_write(int'(REG_ARRAY_LENGTH), len);
    lengths_set++;
  endtask

  // One phase: set the length, load the entries it covers if needed, then
  // issue searches. A scrambled phase overwrites the odd entry in between,
  // which breaks the rotated order.
  task automatic run_phase(input int len, input fill_kind_t kind, input int n_search,
                           input bit scramble);
    int n, rot, i, p, r;
    bit need_fill;
    longint lim, cur;
    logic signed [DATA_W-1:0] seq[$];
    logic signed [DATA_W-1:0] key;
    set_length(len);
    n = (len > DEPTH) ? DEPTH : len;
    need_fill = (kind != FILL_KEEP);
    for (i = 0; i < n; i++)
      if (!loaded[i]) need_fill = 1'b1;
    if (need_fill && n > 0) begin
      if (kind == FILL_NOISE) begin
        for (i = 0; i < n; i++) seq.push_back($urandom);
      end else if (kind == FILL_FLAT) begin
        // Steps of 0..2 give long runs of duplicates.
        cur = longint'($urandom_range(1000)) - 500;
        for (i = 0; i < n; i++) begin
          seq.push_back(cur[DATA_W-1:0]);
          cur += $urandom_range(2);
        end
      end else begin
        // Strictly ascending across as much of the 32-bit range as fits.
        lim = 64'h1_0000_0000 / (n + 1);
        cur = -64'sd2147483648 + longint'($urandom_range(32'(lim - 1)));
        for (i = 0; i < n; i++) begin
          seq.push_back(cur[DATA_W-1:0]);
          cur += $urandom_range(32'(lim), 1);
        end
      end
      rot = $urandom_range(n - 1);
      for (i = 0; i < n; i++) push_write(i, seq[(i + rot) % n]);
    end
    for (i = 0; i < n_search; i++) begin
      r = $urandom_range(99);
      if (scramble && n > 0 && r < 8) begin
        push_write($urandom_range(n - 1), $urandom);
      end else if (n < DEPTH && r >= 97) begin
        // Outside the searched range, so it must not change any answer.
        push_write($urandom_range(DEPTH - 1, n), $urandom);
      end else begin
        p = (n > 0) ? $urandom_range(n - 1) : 0;
        if (n > 0 && r < 60)      key = planned[p];
        else if (n > 0 && r < 75) key = $urandom_range(1) ? planned[p] + 1 : planned[p] - 1;
        else if (r < 90)          key = $urandom;
        else begin
          case ($urandom_range(3))
            0:       key = INT_LO;
            1:       key = INT_HI;
            2:       key = '0;
            default: key = -1;
          endcase
        end
        push_search(key);
      end
    end
    wait_quiet();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int phase_no, pick;
    fill_kind_t kind;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Straight out of reset the length is zero, so nothing can be found.
    push_search('0);
    push_search(INT_LO);
    wait_quiet();

    // Extreme values in order, and both extremes of the entry index.
    push_write(0, INT_LO);
    push_write(1, -1);
    push_write(2, '0);
    push_write(3, INT_HI);
    push_write(DEPTH - 1, 32'sh5555_5555);
    push_write(DEPTH - 1, 32'shAAAA_AAAA);
    set_length(4);
    push_search(INT_LO);
    push_search(INT_HI);
    push_search('0);
    push_search(-1);
    push_search(1);
    push_search(-2);

    // A write to an address with no register behind it leaves the length
    // alone, so the top entry is still reachable.
    wait_quiet();
    cfg_write(REG_SPARE, '0);
    push_search(INT_HI);

    // A genuinely rotated run.
    push_write(0, 30);
    push_write(1, 40);
    push_write(2, 10);
    push_write(3, 20);
    push_search(10);
    push_search(40);
    push_search(25);

    // Bits above the register width are dropped: this sets a length of two.
    set_length(32'hFFFF_F802);
    push_search(40);
    push_search(10);

    // Random part: edge lengths first, then many short arrays.
    run_phase(0, FILL_KEEP, 6, 1'b0);
    run_phase(1, FILL_ROTATED, 8, 1'b0);
    run_phase(2, FILL_ROTATED, 10, 1'b0);

    phase_no = 0;
    while (items_total < 900) begin
      pick = $urandom_range(99);
      kind = (pick < 70) ? FILL_ROTATED : (pick < 85) ? FILL_FLAT : FILL_NOISE;
      // One phase runs with both sides streaming flat out.
      no_gaps = (phase_no == 3);
      run_phase($urandom_range(48, 1), kind, $urandom_range(40, 10), kind == FILL_NOISE);
      phase_no++;
    end
    no_gaps = 1'b0;

    // A full array once, then lengths past the depth that must be clipped.
    run_phase(DEPTH, FILL_ROTATED, 120, 1'b0);
    run_phase((1 << LEN_W) - 1, FILL_KEEP, 40, 1'b0);
    run_phase(1500, FILL_KEEP, 40, 1'b1);
    run_phase($urandom_range(20, 3), FILL_ROTATED, 20, 1'b0);

    // wait_quiet has already drained the block and let it settle.
    $display("Run covered %0d write beats and %0d search beats, %0d of them found.",
             writes_taken, searches_taken, hits_seen);
    $display("Array length was set %0d times, from zero up to the register maximum.",
             lengths_set);
    if (mismatches == 0) begin
      $display("rotated_sorted_search_top test passed");
    end else begin
      $display("rotated_sorted_search_top test failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/rss_pkg.sv
rtl/rss_dp.sv
rtl/rss_ctrl.sv
rtl/rotated_sorted_search_top.sv
bench/tb_rotated_sorted_search_top.sv
